[rtl/acl_pkg.sv]
`default_nettype none
package acl_pkg;
  localparam int SAMPLE_W = 16;
  localparam int LAG_W    = 7;
  localparam int CNT_W    = 21;
  localparam int SUM_W    = 52;
  localparam int PROD_W   = 32;
  localparam int CORR_W   = 32;
  localparam int IDX_W    = 6;
  localparam int REG_W    = 1;
  localparam int DATA_W   = 21;

  typedef enum logic [REG_W-1:0] {
    REG_LAG_COUNT    = 1'b0,
    REG_SAMPLE_COUNT = 1'b1
  } reg_idx_t;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [SUM_W-1:0]    sum_t;
  typedef logic signed [CORR_W-1:0]   corr_t;
  typedef logic [CNT_W-1:0]           cnt_t;
  typedef logic [IDX_W-1:0]           lag_idx_t;

  typedef struct packed {
    logic start;
    sum_t dividend;
    cnt_t divisor;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
    sum_t quotient;
  } div_rsp_t;
endpackage
`default_nettype wire

[rtl/acl_if.sv]
`default_nettype none
interface acl_in_if;
  import acl_pkg::*;
  logic    valid;
  logic    ready;
  sample_t sample;
  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

interface acl_out_if;
  import acl_pkg::*;
  logic     valid;
  logic     ready;
  lag_idx_t lag_index;
  corr_t    correlation;
  logic     count_too_small;
  logic     last_lag;
  modport source (output valid, output lag_index, output correlation,
                  output count_too_small, output last_lag, input ready);
  modport sink (input valid, input lag_index, input correlation,
                input count_too_small, input last_lag, output ready);
endinterface
`default_nettype wire

[rtl/acl_div.sv]
`default_nettype none
module acl_div (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire acl_pkg::div_req_t req,
  output acl_pkg::div_rsp_t      rsp
);
  import acl_pkg::*;

  localparam int STEP_W = $clog2(SUM_W + 1);

  logic [SUM_W-1:0]  quo;
  logic [CNT_W:0]    rem;
  cnt_t              dvs;
  logic              neg;
  logic [STEP_W-1:0] steps;
  logic              busy;
  logic              done;
  logic [CNT_W+1:0]  trial;

  assign trial = {rem, quo[SUM_W-1]} - {2'b00, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy  <= 1'b1;
        neg   <= req.dividend[SUM_W-1];
        quo   <= req.dividend[SUM_W-1] ? SUM_W'(-req.dividend) : req.dividend;
        dvs   <= req.divisor;
        rem   <= '0;
        steps <= STEP_W'(SUM_W);
      end else if (busy) begin
        if (!trial[CNT_W+1]) begin
          rem <= trial[CNT_W:0];
          quo <= {quo[SUM_W-2:0], 1'b1};
        end else begin
          rem <= {rem[CNT_W-1:0], quo[SUM_W-1]};
          quo <= {quo[SUM_W-2:0], 1'b0};
        end
        steps <= steps - 1'b1;
        if (steps == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.busy     = busy;
  assign rsp.done     = done;
  assign rsp.quotient = neg ? -sum_t'(quo) : sum_t'(quo);

  property p_no_restart;
    @(posedge clk) disable iff (rst) busy |-> !req.start;
  endproperty
  a_no_restart: assert property (p_no_restart) else $error("divider restarted while busy");

  property p_done_after_busy;
    @(posedge clk) disable iff (rst) done |-> $past(busy);
  endproperty
  a_done_after_busy: assert property (p_done_after_busy) else $error("done without work");

  property p_rem_bound;
    @(posedge clk) disable iff (rst) busy && !req.start |-> rem < {1'b0, dvs} || dvs == '0;
  endproperty
  a_rem_bound: assert property (p_rem_bound) else $error("remainder out of range");
endmodule
`default_nettype wire

[rtl/autocorrelation_lag_accumulator_unit.sv]
`default_nettype none
// channel   dir  payload                                           handshake
// in_ch     in   sample                                            valid/ready
// out_ch    out  lag_index, correlation, count_too_small, last_lag valid/ready
// cfg       in   wr_index, wr_data                                 wr_en
// An item does one sum-memory read-modify-write per lag through pipe stages a and b.
// An item ending a run adds per lag a read, a load, a 52-step divide and the output
// state, which waits for out_ch ready; no divide when the count is too small.
// Synchronous reset clears control state and sum valid bits; no clearing pass.
// One item at a time: in_ch.ready only while idle; out_ch stalls hold the result.
module autocorrelation_lag_accumulator_unit #(
  parameter int MAX_LAGS    = 64,
  parameter int MAX_SAMPLES = 1048576
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  acl_in_if.sink                        in_ch,
  acl_out_if.source                     out_ch,
  input  wire logic                     wr_en,
  input  wire logic [acl_pkg::REG_W-1:0]  wr_index,
  input  wire logic [acl_pkg::DATA_W-1:0] wr_data
);
  import acl_pkg::*;

  localparam int PTR_W  = (MAX_LAGS > 1) ? $clog2(MAX_LAGS) : 1;
  localparam int LCNT_W = $clog2(MAX_LAGS + 1);

  typedef enum logic [2:0] {S_IDLE, S_MAC, S_DRAIN, S_RD, S_LOAD, S_DIV, S_OUT} state_t;

  state_t state;
  logic [LAG_W-1:0] lag_count;
  cnt_t sample_count;
  cnt_t samples_seen;

  sample_t dl_mem [MAX_LAGS];
  sum_t    sm_mem [MAX_LAGS];
  logic [MAX_LAGS-1:0] vld;
  sample_t dl_q;
  sum_t    sm_q;
  logic    sm_qv;

  logic [PTR_W-1:0]  wp, wp_next;
  sample_t           xr;
  logic [LCNT_W-1:0] eff_l, lc, ic, k;
  cnt_t              eff_n, span, jr;
  logic              too_small, tsr, run_end;
  logic [LCNT_W:0]   rd_sum;
  logic [PTR_W-1:0]  dl_addr, sm_addr;

  logic              a_v, a_add, b_v, b_add;
  logic [LCNT_W-1:0] a_i, b_i;
  logic signed [PROD_W-1:0] b_prod;
  sum_t              b_sum;
  sample_t           mul_a;
  logic              add_now;
  logic [CNT_W:0]    jdiff;

  div_req_t dreq;
  div_rsp_t drsp;

  lag_idx_t o_idx;
  corr_t    o_corr;
  logic     o_ts, o_last, o_v;

  always_comb begin
    if (lag_count == '0) eff_l = LCNT_W'(1);
    else if (lag_count > LAG_W'(MAX_LAGS)) eff_l = LCNT_W'(MAX_LAGS);
    else eff_l = LCNT_W'(lag_count);
    eff_n = (sample_count > CNT_W'(MAX_SAMPLES)) ? CNT_W'(MAX_SAMPLES) : sample_count;
    too_small = eff_n <= CNT_W'(eff_l);
    span = too_small ? '0 : eff_n - CNT_W'(eff_l);
    wp_next = (wp == PTR_W'(MAX_LAGS - 1)) ? '0 : wp + 1'b1;
    rd_sum = (wp >= PTR_W'(ic)) ? (LCNT_W + 1)'(wp) - (LCNT_W + 1)'(ic)
                                : (LCNT_W + 1)'(wp) + (LCNT_W + 1)'(MAX_LAGS)
                                  - (LCNT_W + 1)'(ic);
    dl_addr = rd_sum[PTR_W-1:0];
    sm_addr = (state == S_RD) ? k[PTR_W-1:0] : ic[PTR_W-1:0];
    jdiff = {1'b0, jr} - (CNT_W + 1)'(ic);
    add_now = !jdiff[CNT_W] && (jdiff[CNT_W-1:0] < span);
    mul_a = (a_i == '0) ? xr : dl_q;
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) dl_mem[wp_next] <= in_ch.sample;
    dl_q  <= dl_mem[dl_addr];
    sm_q  <= sm_mem[sm_addr];
    sm_qv <= vld[sm_addr];
    if (b_v && b_add) sm_mem[b_i[PTR_W-1:0]] <= b_sum + sum_t'(b_prod);
  end

  always_ff @(posedge clk) begin
    b_prod <= PROD_W'(mul_a * xr);
    b_sum  <= sm_qv ? sm_q : '0;
    b_i    <= a_i;
    b_add  <= a_add;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      lag_count    <= LAG_W'(64);
      sample_count <= CNT_W'(1024);
      samples_seen <= '0;
      wp           <= '0;
      vld          <= '0;
      a_v          <= 1'b0;
      b_v          <= 1'b0;
      o_v          <= 1'b0;
      dreq.start   <= 1'b0;
    end else begin
      dreq.start <= 1'b0;
      if (wr_en) begin
        unique case (wr_index)
          REG_LAG_COUNT:    lag_count <= wr_data[LAG_W-1:0];
          REG_SAMPLE_COUNT: sample_count <= wr_data[CNT_W-1:0];
          default: ;
        endcase
      end
      a_v <= 1'b0;
      b_v <= a_v;
      if (b_v && b_add) vld[b_i[PTR_W-1:0]] <= 1'b1;
      unique case (state)
        S_IDLE: if (in_ch.valid) begin
          wp      <= wp_next;
          xr      <= in_ch.sample;
          jr      <= samples_seen;
          lc      <= eff_l;
          tsr     <= too_small;
          dreq.divisor <= span;
          run_end <= ({1'b0, samples_seen} + 1'b1) >= {1'b0, eff_n};
          ic      <= '0;
          state   <= S_MAC;
        end
        S_MAC: begin
          a_v   <= 1'b1;
          a_i   <= ic;
          a_add <= add_now;
          ic    <= ic + 1'b1;
          if (ic == lc - 1'b1) state <= S_DRAIN;
        end
        S_DRAIN: if (!a_v && !b_v) begin
          k <= '0;
          if (run_end) state <= S_RD;
          else begin
            samples_seen <= jr + 1'b1;
            state <= S_IDLE;
          end
        end
        S_RD: state <= S_LOAD;
        S_LOAD: begin
          o_idx  <= IDX_W'(k);
          o_ts   <= tsr;
          o_last <= (k == lc - 1'b1);
          if (tsr) begin
            o_corr <= '0;
            o_v    <= 1'b1;
            state  <= S_OUT;
          end else begin
            dreq.dividend <= sm_qv ? sm_q : '0;
            dreq.start    <= 1'b1;
            state         <= S_DIV;
          end
        end
        S_DIV: if (drsp.done) begin
          o_corr <= drsp.quotient[CORR_W-1:0];
          o_v    <= 1'b1;
          state  <= S_OUT;
        end
        S_OUT: if (out_ch.ready) begin
          o_v <= 1'b0;
          if (o_last) begin
            vld          <= '0;
            samples_seen <= '0;
            state        <= S_IDLE;
          end else begin
            k     <= k + 1'b1;
            state <= S_RD;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  acl_div u_div (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));

  assign in_ch.ready           = (state == S_IDLE);
  assign out_ch.valid          = o_v;
  assign out_ch.lag_index      = o_idx;
  assign out_ch.correlation    = o_corr;
  assign out_ch.count_too_small = o_ts;
  assign out_ch.last_lag       = o_last;

  property p_accept_empty;
    @(posedge clk) disable iff (rst) in_ch.valid && in_ch.ready |-> !a_v && !b_v;
  endproperty
  a_accept_empty: assert property (p_accept_empty) else $error("item accepted with pipe busy");

  property p_lag_range;
    @(posedge clk) disable iff (rst) b_v |-> b_i < lc;
  endproperty
  a_lag_range: assert property (p_lag_range) else $error("lag beyond lag count");

  property p_last_idle;
    @(posedge clk) disable iff (rst) out_ch.valid && out_ch.ready && out_ch.last_lag
      |=> in_ch.ready && vld == '0;
  endproperty
  a_last_idle: assert property (p_last_idle) else $error("run not closed after last lag");

  property p_flag_zero;
    @(posedge clk) disable iff (rst) out_ch.valid && out_ch.count_too_small
      |-> out_ch.correlation == '0;
  endproperty
  a_flag_zero: assert property (p_flag_zero) else $error("flagged result not zero");
endmodule
`default_nettype wire

[tb/autocorrelation_lag_accumulator_unit_test.sv]
module autocorrelation_lag_accumulator_unit_test;
  import acl_pkg::*;

  typedef enum logic [0:0] {ROW_CFG, ROW_SAMPLE} row_kind_t;

  typedef struct packed {
    row_kind_t            kind;
    reg_idx_t             idx;
    logic [DATA_W-1:0]    value;
    sample_t              smp;
    logic                 flagged;
  } row_t;

  typedef struct packed {
    lag_idx_t lag_index;
    corr_t    correlation;
    logic     count_too_small;
    logic     last_lag;
  } lag_result_t;

  localparam int LAGS_MAX  = 64;
  localparam int SAMP_MAX  = 1048576;
  localparam int ITEMS     = 430;
  localparam int SETTLE    = 80;

  logic clk;
  logic rst;
  logic wr_en;
  logic [REG_W-1:0] wr_index;
  logic [DATA_W-1:0] wr_data;

  acl_in_if  in_ch ();
  acl_out_if out_ch ();

  autocorrelation_lag_accumulator_unit dut (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch),
    .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data)
  );

  // predictor state
  logic [LAG_W-1:0] lag_count_q;
  logic [CNT_W-1:0] sample_count_q;
  sample_t          delay_line [LAGS_MAX];
  longint           lag_acc [LAGS_MAX];
  logic [CNT_W-1:0] seen_q;

  lag_result_t lag_results_due[$];
  int  failures;
  int  sent;
  int  results_seen;
  bit  quiet;
  bit  held;
  int  hold_left;
  row_t rows[];

  function automatic int eff_lags();
    if (lag_count_q == 0) return 1;
    if (lag_count_q > LAGS_MAX) return LAGS_MAX;
    return lag_count_q;
  endfunction

  function automatic int eff_samples();
    if (sample_count_q > SAMP_MAX) return SAMP_MAX;
    return sample_count_q;
  endfunction

  function automatic void model_config(reg_idx_t idx, logic [DATA_W-1:0] v);
    if (idx == REG_LAG_COUNT) lag_count_q = v[LAG_W-1:0];
    else sample_count_q = v[CNT_W-1:0];
  endfunction

  function automatic void accumulate_lags(sample_t x, bit keep);
    int l_eff;
    int n_eff;
    bit small_n;
    longint span;
    longint j;
    lag_result_t r;
    l_eff = eff_lags();
    n_eff = eff_samples();
    small_n = (n_eff <= l_eff);
    span = small_n ? 0 : longint'(n_eff - l_eff);
    j = longint'(seen_q);
    for (int i = LAGS_MAX - 1; i > 0; i--) delay_line[i] = delay_line[i-1];
    delay_line[0] = x;
    for (int i = 0; i < l_eff; i++)
      if (i <= j && (j - i) < span)
        lag_acc[i] += longint'(delay_line[i]) * longint'(x);
    if (j + 1 >= n_eff) begin
      for (int i = 0; i < l_eff; i++) begin
        r.lag_index = i[IDX_W-1:0];
        r.correlation = small_n ? '0 : corr_t'(lag_acc[i] / span);
        r.count_too_small = small_n;
        r.last_lag = (i == l_eff - 1);
        if (keep) lag_results_due.push_back(r);
        lag_acc[i] = 0;
      end
      for (int i = l_eff; i < LAGS_MAX; i++) lag_acc[i] = 0;
      seen_q = '0;
    end else begin
      seen_q = seen_q + 1'b1;
    end
  endfunction

  task automatic cfg_write(reg_idx_t idx, logic [DATA_W-1:0] v);
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= v;
    @(posedge clk);
    model_config(idx, v);
    wr_en <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (lag_results_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic send_sample(sample_t x, bit flagged);
    lag_result_t r;
    int l_eff;
    if (!quiet && $urandom_range(0, 99) < 19) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.sample <= x;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    if (flagged) begin
      l_eff = eff_lags();
      for (int i = 0; i < l_eff; i++) begin
        r.lag_index = i[IDX_W-1:0];
        r.correlation = '0;
        r.count_too_small = 1'b1;
        r.last_lag = (i == l_eff - 1);
        lag_results_due.push_back(r);
      end
    end
    accumulate_lags(x, !flagged);
    sent++;
    quiet = (sent >= 200 && sent < 280);
  endtask

  function automatic sample_t rand_sample();
    case ($urandom_range(0, 7))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return sample_t'($urandom_range(0, 15)) - 16'sd8;
      default: return sample_t'($urandom);
    endcase
  endfunction

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #100000000;
    $display("autocorrelation_lag_accumulator_unit regression: fail");
    $finish;
  end

  // result side: ready and checking; one long hold while the sender is still offering
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ch.ready <= 1'b0;
    end else if (!held && out_ch.valid && in_ch.valid && !in_ch.ready) begin
      held <= 1'b1;
      hold_left <= 400;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= quiet || ($urandom_range(0, 99) >= 19);
    end
  end

  always @(posedge clk) begin
    lag_result_t e;
    if (!rst && out_ch.valid && out_ch.ready) begin
      results_seen++;
      if (lag_results_due.size() == 0) begin
        $error("unexpected lag result %0d: lag_index %0d", results_seen,
               out_ch.lag_index);
        failures++;
      end else begin
        e = lag_results_due.pop_front();
        if (out_ch.lag_index !== e.lag_index) begin
          $error("lag_index: expected %0d actual %0d", e.lag_index, out_ch.lag_index);
          failures++;
        end
        if (out_ch.correlation !== e.correlation) begin
          $error("correlation: expected %0d actual %0d", e.correlation,
                 out_ch.correlation);
          failures++;
        end
        if (out_ch.count_too_small !== e.count_too_small) begin
          $error("count_too_small: expected %0b actual %0b", e.count_too_small,
                 out_ch.count_too_small);
          failures++;
        end
        if (out_ch.last_lag !== e.last_lag) begin
          $error("last_lag: expected %0b actual %0b", e.last_lag, out_ch.last_lag);
          failures++;
        end
      end
    end
  end

  initial begin
    int l_pick;
    int n_pick;
    int n_run;
    failures = 0;
    sent = 0;
    results_seen = 0;
    quiet = 1'b0;
    held = 1'b0;
    hold_left = 0;
    lag_count_q = 7'd64;
    sample_count_q = 21'd1024;
    seen_q = '0;
    for (int i = 0; i < LAGS_MAX; i++) begin
      delay_line[i] = '0;
      lag_acc[i] = 0;
    end
    rst <= 1'b1;
    wr_en <= 1'b0;
    wr_index <= '0;
    wr_data <= '0;
    in_ch.valid <= 1'b0;
    in_ch.sample <= '0;

    rows = '{
      '{ROW_CFG,    REG_LAG_COUNT,    21'd4,       16'sh0000, 1'b0},
      '{ROW_CFG,    REG_SAMPLE_COUNT, 21'd8,       16'sh0000, 1'b0},
      '{ROW_SAMPLE, REG_LAG_COUNT,    21'd0,       16'sh7fff, 1'b0},
      '{ROW_SAMPLE, REG_LAG_COUNT,    21'd0,       16'sh8000, 1'b0},
      '{ROW_SAMPLE, REG_LAG_COUNT,    21'd0,       16'sh8000, 1'b0},
      '{ROW_SAMPLE, REG_LAG_COUNT,    21'd0,       16'sh7fff, 1'b0},
      '{ROW_SAMPLE, REG_LAG_COUNT,    21'd0,       16'sh0000, 1'b0},
      '{ROW_SAMPLE, REG_LAG_COUNT,    21'd0,       16'sh0001, 1'b0},
      '{ROW_SAMPLE, REG_LAG_COUNT,    21'd0,       16'shffff, 1'b0},
      '{ROW_SAMPLE, REG_LAG_COUNT,    21'd0,       16'sh3039, 1'b0},
      // offered while the previous run drains
      '{ROW_SAMPLE, REG_LAG_COUNT,    21'd0,       16'sh0100, 1'b0},
      // zero sample count: every item closes a flagged run
      '{ROW_CFG,    REG_SAMPLE_COUNT, 21'd0,       16'sh0000, 1'b0},
      '{ROW_SAMPLE, REG_LAG_COUNT,    21'd0,       16'sh0064, 1'b1},
      // lag count zero acts as one
      '{ROW_CFG,    REG_LAG_COUNT,    21'd0,       16'sh0000, 1'b0},
      '{ROW_CFG,    REG_SAMPLE_COUNT, 21'd1,       16'sh0000, 1'b0},
      '{ROW_SAMPLE, REG_LAG_COUNT,    21'd0,       16'shfffb, 1'b1},
      // lag count above range clamps to 64
      '{ROW_CFG,    REG_LAG_COUNT,    21'd127,     16'sh0000, 1'b0},
      '{ROW_CFG,    REG_SAMPLE_COUNT, 21'd2,       16'sh0000, 1'b0},
      '{ROW_SAMPLE, REG_LAG_COUNT,    21'd0,       16'sh0007, 1'b0},
      '{ROW_SAMPLE, REG_LAG_COUNT,    21'd0,       16'sh0009, 1'b1},
      // largest mean: (-1.0 in Q1.15)^2, raw (-32768)^2 = 2^30, over a span of one
      '{ROW_CFG,    REG_SAMPLE_COUNT, 21'd2097151, 16'sh0000, 1'b0},
      '{ROW_CFG,    REG_LAG_COUNT,    21'd1,       16'sh0000, 1'b0},
      '{ROW_CFG,    REG_SAMPLE_COUNT, 21'd2,       16'sh0000, 1'b0},
      '{ROW_SAMPLE, REG_LAG_COUNT,    21'd0,       16'sh8000, 1'b0},
      '{ROW_SAMPLE, REG_LAG_COUNT,    21'd0,       16'sh8000, 1'b0}
    };

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (rows[k]) begin
      if (rows[k].kind == ROW_CFG) begin
        wait_idle();
        cfg_write(rows[k].idx, rows[k].value);
      end else begin
        send_sample(rows[k].smp, rows[k].flagged);
      end
    end

    while (sent < ITEMS) begin
      case ($urandom_range(0, 15))
        0: l_pick = 0;
        1: l_pick = 64;
        2: l_pick = $urandom_range(65, 127);
        3, 4: l_pick = $urandom_range(9, 63);
        default: l_pick = $urandom_range(1, 8);
      endcase
      case ($urandom_range(0, 9))
        0: n_pick = $urandom_range(0, (l_pick == 0) ? 1 : l_pick);
        1: n_pick = l_pick + $urandom_range(40, 120);
        default: n_pick = l_pick + $urandom_range(1, 12);
      endcase
      wait_idle();
      if ($urandom_range(0, 1)) begin
        cfg_write(REG_LAG_COUNT, DATA_W'(l_pick));
        cfg_write(REG_SAMPLE_COUNT, DATA_W'(n_pick));
      end else begin
        cfg_write(REG_SAMPLE_COUNT, DATA_W'(n_pick));
        cfg_write(REG_LAG_COUNT, DATA_W'(l_pick));
      end
      n_run = (eff_samples() == 0) ? 1 : eff_samples();
      if (n_run > 200) n_run = 200;
      if ($urandom_range(0, 7) == 0) n_run = $urandom_range(0, n_run);
      // a flagged run with many lags is slow to drain; keep those short
      if (eff_samples() <= eff_lags() && eff_lags() > 8) n_run = 1;
      if (n_run > ITEMS - sent) n_run = ITEMS - sent;
      for (int k = 0; k < n_run; k++) send_sample(rand_sample(), 1'b0);
    end

    in_ch.valid <= 1'b0;
    while (lag_results_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (failures == 0) begin
      $display("autocorrelation_lag_accumulator_unit regression: pass");
    end else begin
      $display("autocorrelation_lag_accumulator_unit regression: fail");
    end
    $finish;
  end
endmodule

[files.f]
rtl/acl_pkg.sv
rtl/acl_if.sv
rtl/acl_div.sv
rtl/autocorrelation_lag_accumulator_unit.sv
tb/autocorrelation_lag_accumulator_unit_test.sv
